// ----- src/lpht_pkg.sv -----
// Shared constants and controller/datapath handshake types for the linear probing hash table.
`default_nettype none
package lpht_pkg;

	// Table size must be a power of two: the home slot is the masked key sum.
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int KEY_W         = 30;
	localparam int VAL_W         = 20;
	localparam int ENTRY_W       = 1 + 2 * KEY_W + VAL_W;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic load;     // capture request, start at home slot
		logic advance;  // step to next slot, read it
		logic finish;   // emit result, commit insert
		logic clear;    // write one invalid entry of the reset sweep
	} lpht_cmd_t;

	typedef struct packed {
		logic hit;
		logic empty;
		logic last;       // all slots probed
		logic clear_last; // reset sweep at last entry
		logic out_free;
	} lpht_stat_t;

endpackage
`default_nettype wire

// ----- src/lpht_req_if.sv -----
// Request channel: operation, two-part key and value.
`default_nettype none
interface lpht_req_if;
	import lpht_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [KEY_W-1:0] key_a;
	logic [KEY_W-1:0] key_b;
	logic [VAL_W-1:0] value;

	modport source (output valid, output func, output key_a, output key_b, output value,
		input ready);
	modport sink (input valid, input func, input key_a, input key_b, input value,
		output ready);
endinterface
`default_nettype wire

// ----- src/lpht_rsp_if.sv -----
// Response channel: found flag, stored value and status.
`default_nettype none
interface lpht_rsp_if;
	import lpht_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [VAL_W-1:0] value_out;
	logic             status;

	modport source (output valid, output found, output value_out, output status,
		input ready);
	modport sink (input valid, input found, input value_out, input status,
		output ready);
endinterface
`default_nettype wire

// ----- src/lpht_ctrl.sv -----
// Controller state machine: reset sweep, request capture, probe loop, result hand-off.
`default_nettype none
module lpht_ctrl
	import lpht_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire lpht_stat_t stat,
	output lpht_cmd_t       cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_CHECK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_PROBE;
				end
			end
			ST_PROBE: begin
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.hit || stat.empty || stat.last) begin
					// hold here until the output register can take the result
					if (stat.out_free) begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- src/lpht_dp.sv -----
// Datapath: request registers, slot table memory, key compare and output register.
`default_nettype none
module lpht_dp
	import lpht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	lpht_req_if.sink       req,
	lpht_rsp_if.source     rsp,
	input  wire lpht_cmd_t cmd,
	output lpht_stat_t     stat
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// entry layout: {valid, key_b, key_a, value}
	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rd_q;

	logic               func_q;
	logic [2*KEY_W-1:0] key_q;
	logic [VAL_W-1:0]   val_q;
	logic [IDX_W-1:0]   slot_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   clr_q;

	logic               out_valid_q;
	logic               found_q;
	logic [VAL_W-1:0]   value_out_q;
	logic               status_q;

	logic [KEY_W:0]     key_sum;
	logic [IDX_W-1:0]   home;
	logic [IDX_W-1:0]   slot_nxt;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_valid;
	logic [2*KEY_W-1:0] rd_key;
	logic [VAL_W-1:0]   rd_val;
	logic               hit;
	logic               empty;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	assign key_sum  = {1'b0, req.key_a} + {1'b0, req.key_b};
	assign home     = key_sum[IDX_W-1:0];
	assign slot_nxt = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
	// keep the current slot's data while stalled on a full output register
	assign rd_addr  = cmd.advance ? slot_nxt : slot_q;

	assign rd_valid = rd_q[ENTRY_W-1];
	assign rd_key   = rd_q[ENTRY_W-2:VAL_W];
	assign rd_val   = rd_q[VAL_W-1:0];
	assign hit      = rd_valid && (rd_key == key_q);
	assign empty    = !rd_valid;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = {1'b1, key_q, val_q};
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.finish && (func_q == FUNC_INSERT) && (hit || empty)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			key_q  <= {req.key_b, req.key_a};
			val_q  <= req.value;
			slot_q <= home;
			cnt_q  <= '0;
		end else if (cmd.advance) begin
			slot_q <= slot_nxt;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q     <= hit;
			value_out_q <= hit ? rd_val : '0;
			status_q    <= (hit || empty) ? STATUS_OK : STATUS_FULL;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.found     = found_q;
	assign rsp.value_out = value_out_q;
	assign rsp.status    = status_q;

	assign stat.hit        = hit;
	assign stat.empty      = empty;
	assign stat.last       = (cnt_q == LAST_IDX);
	assign stat.clear_last = (clr_q == LAST_IDX);
	assign stat.out_free   = !out_valid_q || rsp.ready;

endmodule
`default_nettype wire

// ----- src/linear_probing_hash_table.sv -----
// Linear probing hash table: one request in, one response out per operation.
// Each operation probes 1..TABLE_ENTRIES slots, one probe per cycle, through the
// registered slot memory read; the result is then held in the output register.
// One operation at a time: no request is taken until the last result is registered.
// Reset: a sweep invalidates every slot; no request is taken during the sweep.
`default_nettype none
module linear_probing_hash_table
	import lpht_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);

	lpht_cmd_t  cmd;
	lpht_stat_t stat;
	logic       ready;

	assign req.ready = ready;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lpht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the linear probing hash table: directed rows, random traffic, full table.
`timescale 1ns / 1ps
module testbench;
	import lpht_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MAX       = '1;
	localparam logic [KEY_W-1:0] RES_A_MAX     = 30'd1000000006;
	localparam logic [KEY_W-1:0] RES_B_MAX     = 30'd1000000016;
	localparam logic [VAL_W-1:0] VAL_MAX       = '1;
	localparam int               RANDOM_OPS    = 600;
	localparam int               FULL_OPS      = 24;
	localparam int               KEY_POOL_MAX  = 256;
	localparam int               LOAD_CAP      = 480;
	localparam int               DRAIN_CYCLES  = TABLE_ENTRIES + 8;
	localparam int               WATCHDOG_LIMIT = 10000;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [VAL_W-1:0] value;
	} table_op_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value_out;
		logic             status;
	} table_rsp_t;

	typedef struct packed {
		table_op_t  op;
		logic       typed;
		table_rsp_t rsp;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic rsp_take = 1'b0;

	lpht_req_if req_if();
	lpht_rsp_if rsp_if();

	assign rsp_if.ready = rsp_take;

	linear_probing_hash_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow of the slot memory
	bit                 slot_valid [TABLE_ENTRIES];
	logic [2*KEY_W-1:0] slot_key   [TABLE_ENTRIES];
	logic [VAL_W-1:0]   slot_val   [TABLE_ENTRIES];
	int                 slots_used;

	table_rsp_t    pending_rsps [$];
	directed_row_t directed_rows [$];
	logic [2*KEY_W-1:0] key_pool [$];
	int            errors = 0;
	int            send_idle_pct = 21;
	int            take_idle_pct = 74;
	int            quiet_cycles = 0;

	function automatic table_rsp_t probe_and_update(input table_op_t op);
		logic [KEY_W:0]     sum;
		logic [2*KEY_W-1:0] key;
		int                 slot;
		bit                 hit;
		bit                 open_slot;
		table_rsp_t         res;
		sum = {1'b0, op.key_a} + {1'b0, op.key_b};
		key = {op.key_b, op.key_a};
		slot = int'(sum % TABLE_ENTRIES);
		hit = 1'b0;
		open_slot = 1'b0;
		for (int n = 0; n < TABLE_ENTRIES; n++) begin
			if (!slot_valid[slot]) begin
				open_slot = 1'b1;
				break;
			end
			if (slot_key[slot] == key) begin
				hit = 1'b1;
				break;
			end
			slot = (slot + 1) % TABLE_ENTRIES;
		end
		res.found = hit;
		res.value_out = hit ? slot_val[slot] : '0;
		res.status = (hit || open_slot) ? STATUS_OK : STATUS_FULL;
		if (op.func == FUNC_INSERT && (hit || open_slot)) begin
			if (!slot_valid[slot])
				slots_used++;
			slot_valid[slot] = 1'b1;
			slot_key[slot] = key;
			slot_val[slot] = op.value;
		end
		return res;
	endfunction

	task automatic add_row(input logic func, input logic [KEY_W-1:0] key_a,
		input logic [KEY_W-1:0] key_b, input logic [VAL_W-1:0] value, input logic typed,
		input logic found, input logic [VAL_W-1:0] value_out, input logic status);
		directed_row_t row;
		row.op = '{func: func, key_a: key_a, key_b: key_b, value: value};
		row.typed = typed;
		row.rsp = '{found: found, value_out: value_out, status: status};
		directed_rows = {directed_rows, row};
	endtask

	task automatic send_request(input table_op_t op, input logic typed, input table_rsp_t typed_rsp);
		table_rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func  <= op.func;
		req_if.key_a <= op.key_a;
		req_if.key_b <= op.key_b;
		req_if.value <= op.value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = probe_and_update(op);
		pending_rsps = {pending_rsps, (typed ? typed_rsp : predicted)};
	endtask

	function automatic logic pick_func();
		return $urandom_range(0, 1) ? FUNC_INSERT : FUNC_LOOKUP;
	endfunction

	// response check and watchdog
	always @(posedge clk) begin
		table_rsp_t got;
		table_rsp_t want;
		if (rsp_if.valid && rsp_take) begin
			got = '{found: rsp_if.found, value_out: rsp_if.value_out, status: rsp_if.status};
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected response found=%0b value_out=%h status=%0b",
					$time, got.found, got.value_out, got.status);
				errors++;
			end else begin
				want = pending_rsps.pop_front();
				if (got.found !== want.found) begin
					$display("%0t: found mismatch, expected %0b, got %0b",
						$time, want.found, got.found);
					errors++;
				end
				if (got.value_out !== want.value_out) begin
					$display("%0t: value_out mismatch, expected %h, got %h",
						$time, want.value_out, got.value_out);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status mismatch, expected %0b, got %0b",
						$time, want.status, got.status);
					errors++;
				end
			end
		end
		rsp_take <= ($urandom_range(0, 99) >= take_idle_pct);
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_take))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no handshake in %0d cycles", $time, quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		table_op_t          op;
		logic [2*KEY_W-1:0] base;
		logic [KEY_W-1:0]   shift;
		int                 pick;
		int                 slot;
		bit                 fresh;

		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func  <= FUNC_LOOKUP;
		req_if.key_a <= '0;
		req_if.key_b <= '0;
		req_if.value <= '0;
		foreach (slot_valid[i]) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_val[i] = '0;
		end
		slots_used = 0;

		// home slot 1022/1023 rows force wrap-around probing into slots 0..5
		add_row(FUNC_LOOKUP, '0, '0, '0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, '0, '0, '0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, '0, '0, VAL_MAX, 1'b1, 1'b1, '0, STATUS_OK);
		add_row(FUNC_INSERT, '0, '0, VAL_MAX, 1'b1, 1'b1, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, '0, '0, '0, 1'b1, 1'b1, VAL_MAX, STATUS_OK);
		add_row(FUNC_INSERT, KEY_MAX, KEY_MAX, 20'h12345, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, RES_A_MAX, RES_B_MAX, 20'hABCDE, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, KEY_MAX, KEY_MAX, '0, 1'b1, 1'b1, 20'h12345, STATUS_OK);
		add_row(FUNC_INSERT, 30'd1022, '0, 20'h0F0F0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, '0, 30'd1022, 20'h55555, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, '0, 30'd1022, '0, 1'b1, 1'b1, 20'h55555, STATUS_OK);
		add_row(FUNC_LOOKUP, 30'd1, 30'd1021, '0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, 30'd1, 30'd1021, 20'hAAAAA, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, '0, 30'd1, '0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, 30'h2AAAAAAA, 30'h15555555, 20'd1, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, 30'h15555555, 30'h2AAAAAAA, 20'd2, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, 30'h15555555, 30'h2AAAAAAA, '0, 1'b1, 1'b1, 20'd2, STATUS_OK);
		add_row(FUNC_LOOKUP, 30'h2AAAAAAA, 30'h15555555, '0, 1'b1, 1'b1, 20'd1, STATUS_OK);
		add_row(FUNC_INSERT, 30'h15555555, 30'h2AAAAAAA, 20'd3, 1'b1, 1'b1, 20'd2, STATUS_OK);
		add_row(FUNC_LOOKUP, KEY_MAX, '0, '0, 1'b1, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, RES_A_MAX, RES_B_MAX, VAL_MAX, 1'b1, 1'b1, 20'hABCDE, STATUS_OK);
		add_row(FUNC_INSERT, 30'd1, 30'd1, 20'd7, 1'b0, 1'b0, '0, STATUS_OK);
		add_row(FUNC_LOOKUP, 30'd1, 30'd1, '0, 1'b0, 1'b0, '0, STATUS_OK);
		add_row(FUNC_INSERT, KEY_MAX, '0, VAL_MAX, 1'b0, 1'b0, '0, STATUS_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].rsp);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i == RANDOM_OPS / 3) begin
				send_idle_pct = 74;
				take_idle_pct <= 21;
			end
			if (i == 2 * RANDOM_OPS / 3) begin
				send_idle_pct = 0;
				take_idle_pct <= 0;
			end
			pick = $urandom_range(0, 99);
			fresh = 1'b1;
			if (key_pool.size() > 0 && pick < 55) begin
				{op.key_b, op.key_a} = key_pool[$urandom_range(0, key_pool.size() - 1)];
				fresh = 1'b0;
			end else if (key_pool.size() > 0 && pick < 75) begin
				// same key sum, so same home slot as a known key
				base = key_pool[$urandom_range(0, key_pool.size() - 1)];
				shift = KEY_W'($urandom);
				op.key_a = base[KEY_W-1:0] + shift;
				op.key_b = base[2*KEY_W-1:KEY_W] - shift;
			end else if (pick < 90) begin
				op.key_a = KEY_W'($urandom_range(0, RES_A_MAX));
				op.key_b = KEY_W'($urandom_range(0, RES_B_MAX));
			end else begin
				op.key_a = KEY_W'($urandom);
				op.key_b = KEY_W'($urandom);
			end
			op.func = (slots_used >= LOAD_CAP) ? FUNC_LOOKUP : pick_func();
			op.value = VAL_W'($urandom);
			if (fresh) begin
				if (key_pool.size() < KEY_POOL_MAX)
					key_pool = {key_pool, {op.key_b, op.key_a}};
				else
					key_pool[$urandom_range(0, KEY_POOL_MAX - 1)] = {op.key_b, op.key_a};
			end
			send_request(op, 1'b0, '0);
		end

		// fill every free slot by aiming fresh keys straight at it
		while (slots_used < TABLE_ENTRIES) begin
			slot = int'($urandom_range(0, TABLE_ENTRIES - 1));
			while (slot_valid[slot])
				slot = (slot + 1) % TABLE_ENTRIES;
			op.func = FUNC_INSERT;
			op.key_b = KEY_W'($urandom);
			op.key_a = KEY_W'(slot) - op.key_b;
			op.value = VAL_W'($urandom);
			send_request(op, 1'b0, '0);
		end

		// full table: misses sweep every slot and report full
		for (int i = 0; i < FULL_OPS; i++) begin
			op.func = pick_func();
			if ($urandom_range(0, 1)) begin
				{op.key_b, op.key_a} = slot_key[$urandom_range(0, TABLE_ENTRIES - 1)];
			end else begin
				op.key_a = KEY_W'($urandom);
				op.key_b = KEY_W'($urandom);
			end
			op.value = VAL_W'($urandom);
			send_request(op, 1'b0, '0);
		end
		req_if.valid <= 1'b0;

		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lpht_pkg.sv
src/lpht_req_if.sv
src/lpht_rsp_if.sv
src/lpht_ctrl.sv
src/lpht_dp.sv
src/linear_probing_hash_table.sv
tb/testbench.sv
